### design/dcbr_pkg.sv
package dcbr_pkg;

   // Request item layout
   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 2;
   localparam int BYTE_W     = 8;

   // Result item layout
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 1;

   // Request kinds carried on req_tuser
   localparam logic [REQ_USER_W-1:0] MODE_EVENT    = 2'd0;
   localparam logic [REQ_USER_W-1:0] MODE_KEY_READ = 2'd1;
   localparam logic [REQ_USER_W-1:0] MODE_AUX_READ = 2'd2;

   // Controller status bits
   localparam int ST_FULL_BIT = 0;
   localparam int ST_AUX_BIT  = 5;

   // Flags carried from the queue access stage to the result register
   typedef struct packed {
      logic read_valid;
      logic from_aux;
      logic byte_stored;
      logic byte_dropped;
      logic went_to_mouse;
   } stage_flags_type;

endpackage

### design/dcbr_ram.sv
module dcbr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/dual_channel_byte_router_fifo.sv
// Channel   Dir  Payload
// req_      in   tuser[1:0] mode; tdata[7:0] status_byte, [15:8] data_byte
// rsp_      out  tdata[0] read_valid, [8:1] read_byte, [9] byte_stored,
//                [10] byte_dropped, [15:11] zero; tuser[0] went_to_mouse
//
// One item per cycle when rsp_tready stays high; each result passes through
// the access stage and then the result register. Pointer checks and the queue
// access happen at the accept edge, and the registered read port of each queue
// RAM holds the byte for the access stage. Reset clears the four pointers and
// both valid flags; queue contents are never cleared. A stall on rsp_ fills the
// result register and then the access stage, after which req_tready falls.
module dual_channel_byte_router_fifo #(
   parameter int DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [7:0] status_byte, [15:8] data_byte
   input  logic [dcbr_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [1:0] mode
   input  logic [dcbr_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] read_valid, [8:1] read_byte, [9] byte_stored, [10] byte_dropped
   output logic [dcbr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [0] went_to_mouse
   output logic [dcbr_pkg::RSP_USER_W-1:0]      rsp_tuser
);
   import dcbr_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

   logic [PW-1:0] key_wr_ptr_ff, key_wr_ptr_in, key_rd_ptr_ff, key_rd_ptr_in;
   logic [PW-1:0] aux_wr_ptr_ff, aux_wr_ptr_in, aux_rd_ptr_ff, aux_rd_ptr_in;
   logic [PW-1:0] key_wr_nxt, key_rd_nxt, aux_wr_nxt, aux_rd_nxt;

   logic            s1_valid_ff, s1_valid_in;
   stage_flags_type s1_flags_ff, s1_flags_in;
   logic            out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0] out_data_ff, out_data_in;
   logic [RSP_USER_W-1:0] out_user_ff, out_user_in;

   logic              accept, advance;
   logic [BYTE_W-1:0] status_byte, data_byte;
   logic              key_full, key_empty, aux_full, aux_empty;
   logic              push_key, push_aux, pop_key, pop_aux;
   logic [BYTE_W-1:0] key_rd_data, aux_rd_data, read_byte;

   assign status_byte = req_tdata[BYTE_W-1:0];
   assign data_byte   = req_tdata[2*BYTE_W-1:BYTE_W];

   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || !out_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign key_wr_nxt = (key_wr_ptr_ff == LAST_SLOT) ? '0 : key_wr_ptr_ff + 1'b1;
   assign key_rd_nxt = (key_rd_ptr_ff == LAST_SLOT) ? '0 : key_rd_ptr_ff + 1'b1;
   assign aux_wr_nxt = (aux_wr_ptr_ff == LAST_SLOT) ? '0 : aux_wr_ptr_ff + 1'b1;
   assign aux_rd_nxt = (aux_rd_ptr_ff == LAST_SLOT) ? '0 : aux_rd_ptr_ff + 1'b1;

   // One slot stays free so that full and empty differ
   assign key_full  = (key_wr_nxt == key_rd_ptr_ff);
   assign key_empty = (key_wr_ptr_ff == key_rd_ptr_ff);
   assign aux_full  = (aux_wr_nxt == aux_rd_ptr_ff);
   assign aux_empty = (aux_wr_ptr_ff == aux_rd_ptr_ff);

   always_comb begin
      s1_flags_in = '0;
      push_key    = 1'b0;
      push_aux    = 1'b0;
      pop_key     = 1'b0;
      pop_aux     = 1'b0;
      case (req_tuser)
         MODE_EVENT: begin
            // Drop spurious events with output-full clear
            if (status_byte[ST_FULL_BIT]) begin
               s1_flags_in.went_to_mouse = status_byte[ST_AUX_BIT];
               if (status_byte[ST_AUX_BIT]) begin
                  s1_flags_in.byte_stored  = !aux_full;
                  s1_flags_in.byte_dropped = aux_full;
                  push_aux                 = accept && !aux_full;
               end else begin
                  s1_flags_in.byte_stored  = !key_full;
                  s1_flags_in.byte_dropped = key_full;
                  push_key                 = accept && !key_full;
               end
            end
         end
         MODE_KEY_READ: begin
            s1_flags_in.read_valid = !key_empty;
            pop_key                = accept && !key_empty;
         end
         MODE_AUX_READ: begin
            s1_flags_in.read_valid = !aux_empty;
            s1_flags_in.from_aux   = 1'b1;
            pop_aux                = accept && !aux_empty;
         end
         default: begin
            s1_flags_in = '0;
         end
      endcase
   end

   assign key_wr_ptr_in = push_key ? key_wr_nxt : key_wr_ptr_ff;
   assign key_rd_ptr_in = pop_key  ? key_rd_nxt : key_rd_ptr_ff;
   assign aux_wr_ptr_in = push_aux ? aux_wr_nxt : aux_wr_ptr_ff;
   assign aux_rd_ptr_in = pop_aux  ? aux_rd_nxt : aux_rd_ptr_ff;

   assign s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   dcbr_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (push_key),
      .wr_addr (key_wr_ptr_ff),
      .wr_data (data_byte),
      .rd_en   (pop_key),
      .rd_addr (key_rd_ptr_ff),
      .rd_data (key_rd_data)
   );

   dcbr_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_aux_ram (
      .clock   (clock),
      .wr_en   (push_aux),
      .wr_addr (aux_wr_ptr_ff),
      .wr_data (data_byte),
      .rd_en   (pop_aux),
      .rd_addr (aux_rd_ptr_ff),
      .rd_data (aux_rd_data)
   );

   // Read data holds while the access stage waits, as no new pop is issued
   assign read_byte = !s1_flags_ff.read_valid ? '0
                    : (s1_flags_ff.from_aux ? aux_rd_data : key_rd_data);

   assign out_data_in = advance
      ? {{(RSP_DATA_W - BYTE_W - 3){1'b0}}, s1_flags_ff.byte_dropped,
         s1_flags_ff.byte_stored, read_byte, s1_flags_ff.read_valid}
      : out_data_ff;
   assign out_user_in  = advance ? s1_flags_ff.went_to_mouse : out_user_ff;
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_wr_ptr_ff <= '0;
         key_rd_ptr_ff <= '0;
         aux_wr_ptr_ff <= '0;
         aux_rd_ptr_ff <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         key_wr_ptr_ff <= key_wr_ptr_in;
         key_rd_ptr_ff <= key_rd_ptr_in;
         aux_wr_ptr_ff <= aux_wr_ptr_in;
         aux_rd_ptr_ff <= aux_rd_ptr_in;
         s1_valid_ff   <= s1_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_flags_ff <= s1_flags_in;
      end
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   // A read of an empty keyboard queue must report nothing
   a_empty_key_read: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == MODE_KEY_READ && key_empty) |=> !s1_flags_ff.read_valid)
      else $error("keyboard read of empty queue reported data");

   // Never both stored and dropped
   a_store_xor_drop: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> !(s1_flags_ff.byte_stored && s1_flags_ff.byte_dropped))
      else $error("item flagged both stored and dropped");

   // Pointers stay inside the queue
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (key_wr_ptr_ff <= LAST_SLOT) && (key_rd_ptr_ff <= LAST_SLOT) &&
      (aux_wr_ptr_ff <= LAST_SLOT) && (aux_rd_ptr_ff <= LAST_SLOT))
      else $error("queue pointer out of range");

   // An empty access stage always takes a new item
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("request stalled with access stage empty");

endmodule

### tb/dcbr_checker.sv
`timescale 1ns / 1ps

module dcbr_checker #(
   parameter int DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   // [7:0] status_byte, [15:8] data_byte
   input  logic [dcbr_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [1:0] mode
   input  logic [dcbr_pkg::REQ_USER_W-1:0]      req_tuser,
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] read_valid, [8:1] read_byte, [9] byte_stored, [10] byte_dropped
   input  logic [dcbr_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // [0] went_to_mouse
   input  logic [dcbr_pkg::RSP_USER_W-1:0]      rsp_tuser,
   output int                                   mismatch_count,
   output int                                   outstanding
);
   import dcbr_pkg::*;

   localparam int LANE_KEY = 0;
   localparam int LANE_AUX = 1;

   typedef struct packed {
      logic              read_valid;
      logic [BYTE_W-1:0] read_byte;
      logic              byte_stored;
      logic              byte_dropped;
      logic              went_to_mouse;
      logic [4:0]        pad;
   } route_result_type;

   logic [BYTE_W-1:0] lane_mem [2][DEPTH];
   int                wr_ptr [2];
   int                rd_ptr [2];
   route_result_type  pending_rsp [$];
   int                errs;

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
      errs           = 0;
   end

   function automatic route_result_type route_item(input logic [REQ_USER_W-1:0] mode,
                                                   input logic [REQ_DATA_W-1:0] payload);
      route_result_type  r;
      logic [BYTE_W-1:0] st;
      logic [BYTE_W-1:0] dat;
      int                lane;
      int                nxt;
      r    = '0;
      st   = payload[BYTE_W-1:0];
      dat  = payload[2*BYTE_W-1:BYTE_W];
      lane = LANE_KEY;
      case (mode)
         MODE_EVENT: begin
            // spurious events leave everything untouched
            if (st[ST_FULL_BIT]) begin
               lane = st[ST_AUX_BIT] ? LANE_AUX : LANE_KEY;
               r.went_to_mouse = st[ST_AUX_BIT];
               nxt = (wr_ptr[lane] + 1) % DEPTH;
               if (nxt == rd_ptr[lane]) begin
                  r.byte_dropped = 1'b1;
               end else begin
                  lane_mem[lane][wr_ptr[lane]] = dat;
                  wr_ptr[lane] = nxt;
                  r.byte_stored = 1'b1;
               end
            end
         end
         MODE_KEY_READ, MODE_AUX_READ: begin
            lane = (mode == MODE_AUX_READ) ? LANE_AUX : LANE_KEY;
            if (wr_ptr[lane] != rd_ptr[lane]) begin
               r.read_valid = 1'b1;
               r.read_byte  = lane_mem[lane][rd_ptr[lane]];
               rd_ptr[lane] = (rd_ptr[lane] + 1) % DEPTH;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : check_proc
      route_result_type got;
      route_result_type want;
      if (reset) begin
         wr_ptr = '{0, 0};
         rd_ptr = '{0, 0};
         pending_rsp.delete();
      end else begin
         // compare first so a result can never match the item of this same edge
         if (rsp_tvalid && rsp_tready) begin
            got.read_valid    = rsp_tdata[0];
            got.read_byte     = rsp_tdata[8:1];
            got.byte_stored   = rsp_tdata[9];
            got.byte_dropped  = rsp_tdata[10];
            got.pad           = rsp_tdata[15:11];
            got.went_to_mouse = rsp_tuser[0];
            if (pending_rsp.size() == 0) begin
               errs++;
               if (errs <= 10)
                  $display("%0t: result with nothing pending: tdata=%h tuser=%h",
                           $realtime, rsp_tdata, rsp_tuser);
            end else begin
               want = pending_rsp.pop_front();
               if (got !== want) begin
                  errs++;
                  if (errs <= 10) begin
                     $write("%0t: mismatch exp rv=%0d rb=%h st=%0d dr=%0d mo=%0d pad=%h",
                            $realtime, want.read_valid, want.read_byte, want.byte_stored,
                            want.byte_dropped, want.went_to_mouse, want.pad);
                     $display(" got rv=%0d rb=%h st=%0d dr=%0d mo=%0d pad=%h",
                              got.read_valid, got.read_byte, got.byte_stored,
                              got.byte_dropped, got.went_to_mouse, got.pad);
                  end
               end
            end
         end
         if (req_tvalid && req_tready)
            pending_rsp.push_back(route_item(req_tuser, req_tdata));
      end
      outstanding    <= pending_rsp.size();
      mismatch_count <= errs;
   end

endmodule

### tb/dual_channel_byte_router_fifo_tb.sv
`timescale 1ns / 1ps

module dual_channel_byte_router_fifo_tb;
   import dcbr_pkg::*;

   localparam int                    DEPTH       = 256;
   localparam logic [REQ_USER_W-1:0] MODE_UNUSED = 2'd3;
   localparam int                    CALM_FROM   = 400;
   localparam int                    CALM_TO     = 1000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   int                    mismatch_count;
   int                    outstanding;
   int                    cycle_cnt = 0;
   logic                  calm;

   dual_channel_byte_router_fifo #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   dcbr_checker #(.DEPTH(DEPTH)) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_cnt <= cycle_cnt + 1;

   // no idling on either side inside this window
   assign calm = (cycle_cnt >= CALM_FROM) && (cycle_cnt < CALM_TO);

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= 25);
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   task automatic send_item(input logic [REQ_USER_W-1:0] mode,
                            input logic [BYTE_W-1:0] status,
                            input logic [BYTE_W-1:0] data);
      while (!calm && $urandom_range(0, 99) < 25) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {data, status};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_mixed(input int count, input int event_pct);
      int                    r;
      logic [BYTE_W-1:0]     st;
      logic [REQ_USER_W-1:0] mode;
      for (int i = 0; i < count; i++) begin
         r    = $urandom_range(0, 99);
         st   = BYTE_W'($urandom_range(0, 255));
         mode = MODE_EVENT;
         if (r < 6) begin
            mode = MODE_UNUSED;
         end else if (r < 14) begin
            st[ST_FULL_BIT] = 1'b0;
         end else if (r < 14 + event_pct) begin
            st[ST_FULL_BIT] = 1'b1;
         end else begin
            mode = $urandom_range(0, 1) ? MODE_AUX_READ : MODE_KEY_READ;
         end
         send_item(mode, st, BYTE_W'($urandom_range(0, 255)));
      end
   endtask

   // push one queue until it overflows, with a little noise mixed in
   task automatic send_fill(input int count, input logic to_aux);
      int                    r;
      logic [BYTE_W-1:0]     st;
      logic [REQ_USER_W-1:0] mode;
      for (int i = 0; i < count; i++) begin
         r    = $urandom_range(0, 99);
         st   = BYTE_W'($urandom_range(0, 255));
         mode = MODE_EVENT;
         if (r < 92) begin
            st[ST_FULL_BIT] = 1'b1;
            st[ST_AUX_BIT]  = to_aux;
         end else if (r < 95) begin
            st[ST_FULL_BIT] = 1'b0;
         end else if (r < 98) begin
            mode = to_aux ? MODE_KEY_READ : MODE_AUX_READ;
         end else begin
            mode = MODE_UNUSED;
         end
         send_item(mode, st, BYTE_W'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reads of empty queues, unused mode, spurious events
      send_item(MODE_KEY_READ, 8'h00, 8'h00);
      send_item(MODE_AUX_READ, 8'hFF, 8'hFF);
      send_item(MODE_UNUSED,   8'hFF, 8'hFF);
      send_item(MODE_EVENT,    8'hFE, 8'hFF);
      send_item(MODE_EVENT,    8'h00, 8'h00);
      // extremes into both queues
      send_item(MODE_EVENT,    8'h01, 8'h00);
      send_item(MODE_EVENT,    8'hDF, 8'hFF);
      send_item(MODE_EVENT,    8'h21, 8'h00);
      send_item(MODE_EVENT,    8'hFF, 8'hFF);
      send_item(MODE_EVENT,    8'h21, 8'hA5);
      send_item(MODE_UNUSED,   8'h00, 8'h00);
      // drain past empty on each side
      send_item(MODE_KEY_READ, 8'hFF, 8'hFF);
      send_item(MODE_KEY_READ, 8'h00, 8'h00);
      send_item(MODE_KEY_READ, 8'h5A, 8'hC3);
      send_item(MODE_AUX_READ, 8'h00, 8'h00);
      send_item(MODE_AUX_READ, 8'hFF, 8'hFF);
      send_item(MODE_AUX_READ, 8'h3C, 8'h96);
      send_item(MODE_AUX_READ, 8'h00, 8'h00);

      send_mixed(100, 45);
      send_fill(290, 1'b0);
      send_mixed(90, 20);
      send_fill(290, 1'b1);
      send_mixed(100, 20);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### filelist.f
design/dcbr_pkg.sv
design/dcbr_ram.sv
design/dual_channel_byte_router_fifo.sv
tb/dcbr_checker.sv
tb/dual_channel_byte_router_fifo_tb.sv
